// ----- rtl/shpd_pkg.sv -----
// ----------------------------------------------------------------------------
// shpd_pkg
// Shared constants, codes and tables of the surge/heading PD controller.
// ----------------------------------------------------------------------------
`default_nettype none

package shpd_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int ATAN_ENTRIES     = 24;

    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_CMD_HEAD = 2'd1;
    localparam logic [1:0] OP_CMD_RATE = 2'd2;
    localparam logic [1:0] OP_RSVD     = 2'd3;

    localparam logic [2:0] REG_SURGE_GAIN = 3'd0;
    localparam logic [2:0] REG_HEAD_GAIN  = 3'd1;
    localparam logic [2:0] REG_DAMP_GAIN  = 3'd2;
    localparam logic [2:0] REG_FORCE_LIM  = 3'd3;
    localparam logic [2:0] REG_TORQUE_LIM = 3'd4;
    localparam logic [2:0] REG_STALE_LIM  = 3'd5;

    localparam logic [15:0] SURGE_GAIN_RST = 16'd1500;
    localparam logic [17:0] HEAD_GAIN_RST  = 18'd60000;
    localparam logic [15:0] DAMP_GAIN_RST  = 16'd25000;
    localparam logic [15:0] FORCE_LIM_RST  = 16'd8000;
    localparam logic [17:0] TORQUE_LIM_RST = 18'd10000;
    localparam logic [15:0] STALE_LIM_RST  = 16'd1000;

    // 2*pi in Q.28, and 0.15 rad in Q.28
    localparam logic [31:0] TWO_PI_Q28    = 32'd1686629713;
    localparam logic [31:0] ERR_LIMIT_Q28 = 32'd40265318;

    // atan(2^-i), 2^32 per turn
    function automatic logic [31:0] f_atan_turn32(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/surge_heading_pd_controller_unit.sv -----
// ----------------------------------------------------------------------------
// surge_heading_pd_controller_unit
// Surge speed and heading/yaw-rate PD controller with CORDIC yaw extraction.
// ----------------------------------------------------------------------------
// Input stream (s_*): s_tuser carries the opcode. A command transfer stores
// the set-points and mode and gives no result. A tick transfer carries
// quaternion, world velocity and measured yaw rate and gives one result
// on the output stream (m_*): world force, yaw torque and the freshness
// flag in m_tuser. Opcode 3 is dropped.
// A tick runs through one shared signed multiplier under a sequencer: nine
// products for the body axis and surge speed, CORDIC_STEPS iterations
// (capped at ATAN_ENTRIES) of the CORDIC vectoring stage (heading mode only,
// skipped for a zero axis), then up to seven more. After a tick transfer
// s_tready stays low until the result register is loaded, so a new transfer
// is accepted only once the previous tick is through. The result sits in an
// output register; if the receiver stalls with a result still held, the
// next tick waits in its last step. Configuration writes (i_cfg_we) take
// effect at once and must be made while idle; the block itself does not
// enforce this. Synchronous reset restores register defaults and clears
// all set-points, the staleness count and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module surge_heading_pd_controller_unit #(
    parameter int CORDIC_STEPS = shpd_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_BITS   = shpd_pkg::ANGLE_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_idx,
    input  wire logic [17:0]  i_cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // cmd_surge, cmd_heading, cmd_yaw_rate, quat_w, quat_x, quat_y, quat_z,
    // vel_x, vel_y, vel_z, meas_yaw_rate (16 bits each)
    input  wire logic [175:0] s_tdata,
    // opcode
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // force_x(17), force_y(17), force_z(17), torque_yaw(19), zero pad(2)
    output logic [71:0]       m_tdata,
    // command_fresh
    output logic [0:0]        m_tuser
);

    localparam int MA   = 40;
    localparam int MB   = (ANGLE_BITS + 1 > 19) ? ANGLE_BITS + 1 : 19;
    localparam int PW   = MA + MB;
    localparam int CW   = 37;
    localparam int EW   = 40;
    localparam int AB   = ANGLE_BITS;
    localparam int NSTP = (CORDIC_STEPS < shpd_pkg::ATAN_ENTRIES) ?
                          CORDIC_STEPS : shpd_pkg::ATAN_ENTRIES;
    localparam int CNW  = $clog2(NSTP + 1);

    localparam logic signed [PW-1:0] ERR_LIM = PW'(shpd_pkg::ERR_LIMIT_Q28);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_YY   = 5'd1;
    localparam logic [4:0] ST_ZZ   = 5'd2;
    localparam logic [4:0] ST_XY   = 5'd3;
    localparam logic [4:0] ST_WZ   = 5'd4;
    localparam logic [4:0] ST_XZ   = 5'd5;
    localparam logic [4:0] ST_WY   = 5'd6;
    localparam logic [4:0] ST_VX   = 5'd7;
    localparam logic [4:0] ST_VY   = 5'd8;
    localparam logic [4:0] ST_VZ   = 5'd9;
    localparam logic [4:0] ST_CI   = 5'd10;
    localparam logic [4:0] ST_CR   = 5'd11;
    localparam logic [4:0] ST_ERR  = 5'd12;
    localparam logic [4:0] ST_ERR2 = 5'd13;
    localparam logic [4:0] ST_E    = 5'd14;
    localparam logic [4:0] ST_SG   = 5'd15;
    localparam logic [4:0] ST_T1   = 5'd16;
    localparam logic [4:0] ST_T2   = 5'd17;
    localparam logic [4:0] ST_FX   = 5'd18;
    localparam logic [4:0] ST_FY   = 5'd19;
    localparam logic [4:0] ST_FZ   = 5'd20;
    localparam logic [4:0] ST_DONE = 5'd21;

    // configuration
    logic [15:0] r_sg, r_yd, r_fl, r_sl;
    logic [17:0] r_hg, r_tl;
    // command state
    logic signed [15:0] r_dsurge, r_dyaw;
    logic [15:0]        r_dhead, r_ticks;
    logic               r_hmode, r_have;
    // tick working state
    logic [4:0]         r_state;
    logic               r_fresh, r_hm;
    logic signed [15:0] r_ds, r_dr;
    logic signed [15:0] r_qw, r_qx, r_qy, r_qz, r_vx, r_vy, r_vz, r_meas;
    logic signed [PW-1:0] r_prod, r_t, r_vb;
    logic signed [MA-1:0] r_ax, r_ay, r_az;
    logic signed [CW-1:0] r_cx, r_cy;
    logic [AB-1:0]        r_z;
    logic [CNW-1:0]       r_cnt;
    logic signed [31:0]   r_err;
    logic signed [EW-1:0] r_e;
    logic signed [16:0]   r_dm;
    logic signed [16:0]   r_fs, r_fx, r_fy;
    logic signed [18:0]   r_tq;
    logic                 r_ovalid;
    logic [71:0]          r_odata;
    logic                 r_ofresh;

    logic signed [MA-1:0] mul_a;
    logic signed [MB-1:0] mul_b;
    logic                 s_xfer;
    logic                 tick_fresh;

    function automatic logic signed [PW-1:0] f_rshr(input logic signed [PW-1:0] v,
                                                    input int k);
        logic signed [PW-1:0] one;
        one = PW'(1);
        return (v + (one <<< (k - 1))) >>> k;
    endfunction

    function automatic logic signed [PW-1:0] f_clamp(input logic signed [PW-1:0] v,
                                                     input logic signed [PW-1:0] lim);
        logic signed [PW-1:0] r;
        r = v;
        if (v > lim) begin
            r = lim;
        end else if (v < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

    assign s_tready = (r_state == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = r_ovalid;
    assign m_tdata  = r_odata;
    assign m_tuser  = r_ofresh;
    assign tick_fresh = r_have && (r_ticks < r_sl);

    // heading error operands
    logic [23:0]          dh_full;
    logic [AB-1:0]        dh, dd;
    logic signed [AB:0]   eu;
    always_comb begin
        dh_full = {r_dhead, 8'd0} >> (24 - AB);
        dh      = dh_full[AB-1:0];
        dd      = dh - r_z;
        if (dd == {1'b1, {(AB-1){1'b0}}}) begin
            eu = $signed({1'b0, dd});
        end else begin
            eu = $signed({dd[AB-1], dd});
        end
    end

    // CORDIC step
    logic signed [CW-1:0] cx_sh, cy_sh;
    logic [32:0]          atan_r;
    logic [AB-1:0]        atan_a;
    always_comb begin
        cx_sh  = r_cx >>> r_cnt;
        cy_sh  = r_cy >>> r_cnt;
        atan_r = {1'b0, shpd_pkg::f_atan_turn32(5'(r_cnt))} +
                 (33'd1 << (31 - AB));
        atan_a = AB'(atan_r >> (32 - AB));
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = MA'(r_qy);
        mul_b = MB'(r_qy);
        unique case (r_state)
            ST_ZZ:   begin mul_a = MA'(r_qz);  mul_b = MB'(r_qz); end
            ST_XY:   begin mul_a = MA'(r_qx);  mul_b = MB'(r_qy); end
            ST_WZ:   begin mul_a = MA'(r_qw);  mul_b = MB'(r_qz); end
            ST_XZ:   begin mul_a = MA'(r_qx);  mul_b = MB'(r_qz); end
            ST_WY:   begin mul_a = MA'(r_qw);  mul_b = MB'(r_qy); end
            ST_VX:   begin mul_a = r_ax;       mul_b = MB'(r_vx); end
            ST_VY:   begin mul_a = r_ay;       mul_b = MB'(r_vy); end
            ST_VZ:   begin mul_a = r_az;       mul_b = MB'(r_vz); end
            ST_ERR:  begin
                mul_a = MA'($signed({1'b0, shpd_pkg::TWO_PI_Q28}));
                mul_b = MB'(eu);
            end
            ST_SG:   begin mul_a = r_e; mul_b = MB'($signed({1'b0, r_sg})); end
            ST_T1:   begin
                if (r_hm) begin
                    mul_a = MA'(r_err);
                    mul_b = MB'($signed({1'b0, r_hg}));
                end else begin
                    mul_a = MA'(r_dm);
                    mul_b = MB'($signed({1'b0, r_yd}));
                end
            end
            ST_T2:   begin mul_a = MA'(r_meas); mul_b = MB'($signed({1'b0, r_yd})); end
            ST_FX:   begin mul_a = r_ax; mul_b = MB'(r_fs); end
            ST_FY:   begin mul_a = r_ay; mul_b = MB'(r_fs); end
            ST_FZ,
            ST_DONE: begin mul_a = r_az; mul_b = MB'(r_fs); end
            default: begin mul_a = MA'(r_qy); mul_b = MB'(r_qy); end
        endcase
    end

    // helpers on the product register
    logic signed [PW-1:0] lim_f, lim_t, lim_o, tq_sum, err_full, fz_full;
    logic signed [PW-1:0] vb_sh, ds_sh;
    always_comb begin
        lim_f    = PW'($signed({1'b0, r_fl}));
        lim_t    = PW'($signed({1'b0, r_tl}));
        lim_o    = PW'(65535);
        tq_sum   = r_hm ? (r_t - (r_prod <<< 16)) : r_t;
        err_full = f_rshr(r_prod, AB);
        fz_full  = f_clamp(f_rshr(r_prod, 30), lim_o);
        vb_sh    = f_rshr(r_vb, 14);
        ds_sh    = PW'(r_ds) <<< 16;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(mul_a) * PW'(mul_b);
        if (!i_rst_n) begin
            r_sg     <= shpd_pkg::SURGE_GAIN_RST;
            r_hg     <= shpd_pkg::HEAD_GAIN_RST;
            r_yd     <= shpd_pkg::DAMP_GAIN_RST;
            r_fl     <= shpd_pkg::FORCE_LIM_RST;
            r_tl     <= shpd_pkg::TORQUE_LIM_RST;
            r_sl     <= shpd_pkg::STALE_LIM_RST;
            r_dsurge <= '0;
            r_dyaw   <= '0;
            r_dhead  <= '0;
            r_ticks  <= '0;
            r_hmode  <= 1'b0;
            r_have   <= 1'b0;
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    shpd_pkg::REG_SURGE_GAIN: r_sg <= i_cfg_data[15:0];
                    shpd_pkg::REG_HEAD_GAIN:  r_hg <= i_cfg_data;
                    shpd_pkg::REG_DAMP_GAIN:  r_yd <= i_cfg_data[15:0];
                    shpd_pkg::REG_FORCE_LIM:  r_fl <= i_cfg_data[15:0];
                    shpd_pkg::REG_TORQUE_LIM: r_tl <= i_cfg_data;
                    shpd_pkg::REG_STALE_LIM:  r_sl <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (r_ovalid && m_tready && r_state != ST_DONE) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_xfer) begin
                        if (s_tuser == shpd_pkg::OP_CMD_HEAD ||
                            s_tuser == shpd_pkg::OP_CMD_RATE) begin
                            r_dsurge <= $signed(s_tdata[15:0]);
                            r_dhead  <= s_tdata[31:16];
                            r_dyaw   <= $signed(s_tdata[47:32]);
                            r_hmode  <= (s_tuser == shpd_pkg::OP_CMD_HEAD);
                            r_ticks  <= '0;
                            r_have   <= 1'b1;
                        end else if (s_tuser == shpd_pkg::OP_TICK) begin
                            r_fresh <= tick_fresh;
                            r_hm    <= tick_fresh && r_hmode;
                            r_ds    <= tick_fresh ? r_dsurge : 16'sd0;
                            r_dr    <= tick_fresh ? r_dyaw : 16'sd0;
                            if (r_ticks != 16'hFFFF) begin
                                r_ticks <= r_ticks + 16'd1;
                            end
                            r_qw    <= $signed(s_tdata[63:48]);
                            r_qx    <= $signed(s_tdata[79:64]);
                            r_qy    <= $signed(s_tdata[95:80]);
                            r_qz    <= $signed(s_tdata[111:96]);
                            r_vx    <= $signed(s_tdata[127:112]);
                            r_vy    <= $signed(s_tdata[143:128]);
                            r_vz    <= $signed(s_tdata[159:144]);
                            r_meas  <= $signed(s_tdata[175:160]);
                            r_state <= ST_YY;
                        end
                    end
                end
                ST_YY: r_state <= ST_ZZ;
                ST_ZZ: begin
                    r_t     <= r_prod;
                    r_state <= ST_XY;
                end
                ST_XY: begin
                    r_ax    <= MA'((PW'(1) <<< 30) - ((r_t + r_prod) <<< 1));
                    r_state <= ST_WZ;
                end
                ST_WZ: begin
                    r_t     <= r_prod;
                    r_state <= ST_XZ;
                end
                ST_XZ: begin
                    r_ay    <= MA'((r_t + r_prod) <<< 1);
                    r_state <= ST_WY;
                end
                ST_WY: begin
                    r_t     <= r_prod;
                    r_state <= ST_VX;
                end
                ST_VX: begin
                    r_az    <= MA'((r_t - r_prod) <<< 1);
                    r_state <= ST_VY;
                end
                ST_VY: begin
                    r_t     <= r_prod;
                    r_state <= ST_VZ;
                end
                ST_VZ: begin
                    r_t     <= r_t + r_prod;
                    r_state <= ST_CI;
                end
                ST_CI: begin
                    r_vb  <= r_t + r_prod;
                    r_cnt <= '0;
                    if (r_ax < 0) begin
                        if (r_ay >= 0) begin
                            r_cx <= CW'(r_ay);
                            r_cy <= -CW'(r_ax);
                            r_z  <= AB'(1) << (AB - 2);
                        end else begin
                            r_cx <= -CW'(r_ay);
                            r_cy <= CW'(r_ax);
                            r_z  <= -(AB'(1) << (AB - 2));
                        end
                    end else begin
                        r_cx <= CW'(r_ax);
                        r_cy <= CW'(r_ay);
                        r_z  <= '0;
                    end
                    // zero axis: yaw stays zero
                    if (!r_hm) begin
                        r_state <= ST_E;
                    end else if (r_ax == 0 && r_ay == 0) begin
                        r_state <= ST_ERR;
                    end else begin
                        r_state <= ST_CR;
                    end
                end
                ST_CR: begin
                    if (r_cy >= 0) begin
                        r_cx <= r_cx + cy_sh;
                        r_cy <= r_cy - cx_sh;
                        r_z  <= r_z + atan_a;
                    end else begin
                        r_cx <= r_cx - cy_sh;
                        r_cy <= r_cy + cx_sh;
                        r_z  <= r_z - atan_a;
                    end
                    r_cnt <= r_cnt + CNW'(1);
                    if (r_cnt == CNW'(NSTP - 1)) begin
                        r_state <= ST_ERR;
                    end
                end
                ST_ERR: r_state <= ST_ERR2;
                ST_ERR2: begin
                    r_err <= 32'(err_full);
                    if (err_full > ERR_LIM || err_full < -ERR_LIM) begin
                        r_ds <= 16'sd0;
                    end
                    r_state <= ST_E;
                end
                ST_E: begin
                    r_e     <= EW'(ds_sh - vb_sh);
                    r_dm    <= 17'(r_dr) - 17'(r_meas);
                    r_state <= ST_SG;
                end
                ST_SG: r_state <= ST_T1;
                ST_T1: begin
                    r_fs    <= 17'(f_clamp(f_rshr(r_prod, 24), lim_f));
                    r_state <= ST_T2;
                end
                ST_T2: begin
                    r_t     <= r_hm ? r_prod : (r_prod <<< 16);
                    r_state <= ST_FX;
                end
                ST_FX: begin
                    r_tq    <= 19'(f_clamp(f_rshr(tq_sum, 28), lim_t));
                    r_state <= ST_FY;
                end
                ST_FY: begin
                    r_fx    <= 17'(fz_full);
                    r_state <= ST_FZ;
                end
                ST_FZ: begin
                    r_fy    <= 17'(fz_full);
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_ovalid || m_tready) begin
                        r_odata  <= {2'b00, r_tq, 17'(fz_full), r_fy, r_fx};
                        r_ofresh <= r_fresh;
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == ST_DONE))
        else $error("result register loaded outside the final step");

    a_cmd_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_xfer && (s_tuser == shpd_pkg::OP_CMD_HEAD || s_tuser == shpd_pkg::OP_CMD_RATE))
        |=> (r_ticks == 16'd0 && r_have))
        else $error("command transfer did not restart staleness count");

    a_cordic_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CR) |-> (r_cnt < CNW'(NSTP)))
        else $error("CORDIC iteration count overrun");

    a_stale_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_xfer && s_tuser == shpd_pkg::OP_TICK && !tick_fresh)
        |=> (!r_hm && r_ds == 16'sd0 && r_dr == 16'sd0))
        else $error("stale tick kept set-points");

endmodule

`default_nettype wire
